@@ rtl/core/tpjs_pkg.sv @@
// Shared types and constants of the tank pump job sequencer.
// Item layouts, job queue entry, configuration bundle, queue control structs.
// No dependencies.
`default_nettype none

package tpjs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 8;

   // action codes
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_REQUEST = 2'd1;
   localparam logic [1:0] ACT_ALARM   = 2'd2;

   // request status codes
   localparam logic [1:0] REQ_NONE     = 2'd0;
   localparam logic [1:0] REQ_ACCEPTED = 2'd1;
   localparam logic [1:0] REQ_REJECTED = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_DISTANCE  = 2'd0;
   localparam logic [1:0] CSR_STALL_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_MIN_CHANGE    = 2'd2;
   localparam logic [1:0] CSR_MAX_VOLUME    = 2'd3;

   localparam int CSR_DATA_W = 16;

   // reset values; max volume is 2.05 L in whole mL
   localparam logic [9:0]  MAX_DISTANCE_RST  = 10'd20;
   localparam logic [15:0] STALL_TIMEOUT_RST = 16'd5000;
   localparam logic [11:0] MIN_CHANGE_RST    = 12'd20;
   localparam logic [11:0] MAX_VOLUME_RST    = 12'd2050;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] level_ml;
      logic [9:0]  distance_cm;
      logic [11:0] job_amount;
      logic        job_fill;
   } req_type;

   typedef struct packed {
      logic        fill_pump_on;
      logic        drain_pump_on;
      logic [2:0]  mode;
      logic [1:0]  request_status;
      logic        job_done;
      logic [3:0]  queued_jobs;
   } rsp_type;

   typedef struct packed {
      logic        fill;
      logic [11:0] amount;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   typedef struct packed {
      logic [9:0]  max_distance;
      logic [15:0] stall_timeout;
      logic [11:0] min_change;
      logic [11:0] max_volume;
   } cfg_type;

   typedef struct packed {
      logic    push;
      logic    pop;
      job_type entry;
   } queue_cmd_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/tank_pump_job_sequencer.sv @@
// Tank pump job sequencer, top level.
// Input channel req_*: one item per cycle while not stalled, a tick with level and
// sensor distance, a job request, or an overflow alarm. Each accepted item
// gives exactly one result item on rsp_* with pump drives, mode, request
// status, job-done pulse and queue occupancy.
// The result is registered and appears in the cycle after the item is accepted.
// One item per cycle while req_stall is low. The job queue RAM reads the next head
// entry every cycle, and a push to that entry is forwarded around the RAM,
// so back-to-back requests and ticks do not wait.
// Stall: rsp_stall holds the result register; req_stall rises only while a
// result is waiting and the receiver stalls, so a new item is taken in the
// same cycle the old result leaves.
// Reset (synchronous): idle mode, empty queue, configuration to defaults.
// Queue RAM contents are not cleared; only written entries are ever read.
// Configuration (csr_*) is written one register per cycle; write it only while idle, the block does not enforce this.
// Uses tpjs_pkg, tpjs_queue, tpjs_ctrl.
`default_nettype none

module tank_pump_job_sequencer #(
   parameter int QUEUE_DEPTH = tpjs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tpjs_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tpjs_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write_en,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [tpjs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tpjs_pkg::cfg_type        cfg_ff;
   tpjs_pkg::queue_cmd_type  qcmd;
   tpjs_pkg::queue_stat_type qstat;
   tpjs_pkg::rsp_type        rsp_next;
   tpjs_pkg::rsp_type        rsp_data_ff;
   logic [CW-1:0]            qcount;
   logic                     accept;
   logic                     rsp_valid_ff, rsp_valid_in;

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_distance  <= tpjs_pkg::MAX_DISTANCE_RST;
         cfg_ff.stall_timeout <= tpjs_pkg::STALL_TIMEOUT_RST;
         cfg_ff.min_change    <= tpjs_pkg::MIN_CHANGE_RST;
         cfg_ff.max_volume    <= tpjs_pkg::MAX_VOLUME_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tpjs_pkg::CSR_MAX_DISTANCE:  cfg_ff.max_distance  <= csr_wdata[9:0];
            tpjs_pkg::CSR_STALL_TIMEOUT: cfg_ff.stall_timeout <= csr_wdata[15:0];
            tpjs_pkg::CSR_MIN_CHANGE:    cfg_ff.min_change    <= csr_wdata[11:0];
            tpjs_pkg::CSR_MAX_VOLUME:    cfg_ff.max_volume    <= csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   tpjs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .stat  (qstat),
      .count (qcount)
   );

   tpjs_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .qstat  (qstat),
      .qcount (qcount),
      .qcmd   (qcmd),
      .rsp    (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/tpjs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tpjs_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/tpjs_queue.sv @@
// Job queue: head pointer and fill count around one RAM, with write-to-read
// forwarding so the head entry is valid every cycle. Uses tpjs_pkg, tpjs_ram.
`default_nettype none

module tpjs_queue #(
   parameter int QUEUE_DEPTH = tpjs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tpjs_pkg::queue_cmd_type          cmd,
   output tpjs_pkg::queue_stat_type              stat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW:0]   tail_sum;
   logic [PW-1:0] wr_addr;
   logic [tpjs_pkg::JOB_W-1:0] rd_data;
   logic          fwd_ff, fwd_in;
   tpjs_pkg::job_type fwd_data_ff;

   always_comb begin
      tail_sum = {1'b0, head_ff} + (PW+1)'(count_ff);
      if (tail_sum >= (PW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (PW+1)'(QUEUE_DEPTH);
      end
      wr_addr = tail_sum[PW-1:0];

      head_in = head_ff;
      if (cmd.pop) begin
         if (head_ff == PW'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      count_in = count_ff + CW'(cmd.push) - CW'(cmd.pop);
      // a write landing on the entry being read this cycle bypasses the RAM
      fwd_in = cmd.push && (wr_addr == head_in);
   end

   tpjs_ram #(
      .WIDTH (tpjs_pkg::JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_addr),
      .wr_data (cmd.entry),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         fwd_ff   <= fwd_in;
      end
      fwd_data_ff <= cmd.entry;
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff >= CW'(QUEUE_DEPTH));
   assign stat.head  = fwd_ff ? fwd_data_ff : tpjs_pkg::job_type'(rd_data);
   assign count      = count_ff;

endmodule

`default_nettype wire

@@ rtl/core/tpjs_ctrl.sv @@
// Pump controller: mode state, projected volume, target and stall check.
// Issues queue push/pop and forms the result item. Uses tpjs_pkg.
`default_nettype none

module tpjs_ctrl #(
   parameter int QUEUE_DEPTH = tpjs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire tpjs_pkg::req_type                req,
   input  wire tpjs_pkg::cfg_type                cfg,
   input  wire tpjs_pkg::queue_stat_type         qstat,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] qcount,
   output tpjs_pkg::queue_cmd_type               qcmd,
   output tpjs_pkg::rsp_type                     rsp
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_EXEC  = 3'd1,
      MODE_ERROR = 3'd2,
      MODE_EMERG = 3'd3,
      MODE_MAINT = 3'd4
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic [11:0]        proj_ff, proj_in;
   logic               synced_ff, synced_in;
   logic signed [13:0] target_ff, target_in;
   logic [11:0]        check_ff, check_in;
   logic [15:0]        timer_ff, timer_in;

   logic signed [13:0] level_s, amount_s, proj_s, maxv_s;
   logic [11:0]        diff;
   logic               reached;
   logic               done;
   logic [1:0]         status;
   logic [CW-1:0]      count_next;

   always_comb begin
      mode_in   = mode_ff;
      proj_in   = proj_ff;
      synced_in = synced_ff;
      target_in = target_ff;
      check_in  = check_ff;
      timer_in  = timer_ff;
      qcmd      = '0;
      done      = 1'b0;
      status    = tpjs_pkg::REQ_NONE;

      level_s  = $signed({2'b00, req.level_ml});
      amount_s = $signed({2'b00, req.job_amount});
      maxv_s   = $signed({2'b00, cfg.max_volume});
      proj_s   = req.job_fill ? $signed({2'b00, proj_ff}) + amount_s
                              : $signed({2'b00, proj_ff}) - amount_s;
      diff     = (req.level_ml >= check_ff) ? req.level_ml - check_ff
                                            : check_ff - req.level_ml;
      reached  = qstat.head.fill ? (level_s >= target_ff) : (level_s <= target_ff);

      qcmd.entry.fill   = req.job_fill;
      qcmd.entry.amount = req.job_amount;

      if (accept) begin
         unique case (req.action)
            tpjs_pkg::ACT_TICK: begin
               if (!synced_ff) begin
                  proj_in   = req.level_ml;
                  synced_in = 1'b1;
               end
               if (req.distance_cm > cfg.max_distance) begin
                  if (mode_in != MODE_MAINT && mode_in != MODE_EMERG) begin
                     mode_in = MODE_MAINT;
                  end
               end else if (mode_in == MODE_MAINT) begin
                  mode_in = MODE_IDLE;
               end

               if (mode_in == MODE_IDLE) begin
                  if (!qstat.empty) begin
                     check_in  = req.level_ml;
                     target_in = qstat.head.fill
                                 ? level_s + $signed({2'b00, qstat.head.amount})
                                 : level_s - $signed({2'b00, qstat.head.amount});
                     timer_in  = '0;
                     mode_in   = MODE_EXEC;
                  end
               end else if (mode_in == MODE_EXEC) begin
                  if (reached) begin
                     qcmd.pop = 1'b1;
                     done     = 1'b1;
                     mode_in  = MODE_IDLE;
                  end
                  // stall check runs even on the tick that retires the job
                  if (timer_ff >= cfg.stall_timeout) begin
                     if (diff < cfg.min_change) begin
                        mode_in = MODE_ERROR;
                     end else begin
                        timer_in = '0;
                        check_in = req.level_ml;
                     end
                  end else begin
                     timer_in = timer_ff + 16'd1;
                  end
               end
            end
            tpjs_pkg::ACT_REQUEST: begin
               if ((mode_ff == MODE_IDLE || mode_ff == MODE_EXEC) && !qstat.full
                   && !proj_s[13] && proj_s <= maxv_s) begin
                  qcmd.push = 1'b1;
                  proj_in   = proj_s[11:0];
                  status    = tpjs_pkg::REQ_ACCEPTED;
               end else begin
                  status    = tpjs_pkg::REQ_REJECTED;
               end
            end
            tpjs_pkg::ACT_ALARM: begin
               mode_in = MODE_EMERG;
            end
            default: begin
            end
         endcase
      end

      count_next = qcount + CW'(qcmd.push) - CW'(qcmd.pop);

      rsp.fill_pump_on   = (mode_in == MODE_EXEC) && (count_next != '0) && qstat.head.fill;
      rsp.drain_pump_on  = (mode_in == MODE_EXEC) && (count_next != '0) && !qstat.head.fill;
      rsp.mode           = mode_in;
      rsp.request_status = status;
      rsp.job_done       = done;
      rsp.queued_jobs    = 4'(count_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         proj_ff   <= '0;
         synced_ff <= 1'b0;
         target_ff <= '0;
         check_ff  <= '0;
         timer_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         proj_ff   <= proj_in;
         synced_ff <= synced_in;
         target_ff <= target_in;
         check_ff  <= check_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

`default_nettype wire
